FILE: src/flpc_pkg.sv
// Shared types and constants for the face landmark posture classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package flpc_pkg;

    localparam int MOVE_THR_W  = 27;
    localparam int SLOPE_THR_W = 4;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int NUM_PTS     = 3;

    localparam logic [MOVE_THR_W-1:0]  MOVE_THR_RESET  = MOVE_THR_W'(24000);
    localparam logic [SLOPE_THR_W-1:0] SLOPE_THR_RESET = SLOPE_THR_W'(3);

    typedef enum logic [2:0] {
        POSTURE_NORMAL = 3'd0,
        POSTURE_NEAR   = 3'd1,
        POSTURE_FAR    = 3'd2,
        POSTURE_LEFT   = 3'd3,
        POSTURE_RIGHT  = 3'd4,
        POSTURE_UP     = 3'd5,
        POSTURE_DOWN   = 3'd6
    } posture_t;

    typedef enum logic [2:0] {
        CFG_REF_LEFT_EYE_X  = 3'd0,
        CFG_REF_LEFT_EYE_Y  = 3'd1,
        CFG_REF_RIGHT_EYE_X = 3'd2,
        CFG_REF_RIGHT_EYE_Y = 3'd3,
        CFG_REF_MOUTH_X     = 3'd4,
        CFG_REF_MOUTH_Y     = 3'd5,
        CFG_MOVE_THRESHOLD  = 3'd6,
        CFG_SLOPE_THRESHOLD = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [MOVE_THR_W-1:0]  move_threshold;
        logic [SLOPE_THR_W-1:0] slope_threshold;
    } thr_cfg_t;

    typedef struct packed {
        logic any_dx_zero;
        logic all_dx_pos;
        logic all_dy_pos;
    } move_flags_t;

endpackage

`default_nettype wire

FILE: src/flpc_cfg.sv
// APB register file: reference triangle and the two thresholds.
// Depends on flpc_pkg.
`default_nettype none

module flpc_cfg import flpc_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic      [CFG_DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic      [COORD_BITS-1:0]  ref_x [NUM_PTS],
    output logic      [COORD_BITS-1:0]  ref_y [NUM_PTS],
    output thr_cfg_t                    thr
);

    logic [COORD_BITS-1:0]  ref_x_reg [NUM_PTS];
    logic [COORD_BITS-1:0]  ref_y_reg [NUM_PTS];
    logic [MOVE_THR_W-1:0]  move_thr_reg;
    logic [SLOPE_THR_W-1:0] slope_thr_reg;
    cfg_idx_t               idx;
    logic                   wr_en;

    assign idx    = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PTS; i++) begin
                ref_x_reg[i] <= '0;
                ref_y_reg[i] <= '0;
            end
            move_thr_reg  <= MOVE_THR_RESET;
            slope_thr_reg <= SLOPE_THR_RESET;
        end else if (wr_en) begin
            case (idx)
                CFG_REF_LEFT_EYE_X:  ref_x_reg[0] <= pwdata[COORD_BITS-1:0];
                CFG_REF_LEFT_EYE_Y:  ref_y_reg[0] <= pwdata[COORD_BITS-1:0];
                CFG_REF_RIGHT_EYE_X: ref_x_reg[1] <= pwdata[COORD_BITS-1:0];
                CFG_REF_RIGHT_EYE_Y: ref_y_reg[1] <= pwdata[COORD_BITS-1:0];
                CFG_REF_MOUTH_X:     ref_x_reg[2] <= pwdata[COORD_BITS-1:0];
                CFG_REF_MOUTH_Y:     ref_y_reg[2] <= pwdata[COORD_BITS-1:0];
                CFG_MOVE_THRESHOLD:  move_thr_reg <= pwdata[MOVE_THR_W-1:0];
                CFG_SLOPE_THRESHOLD: slope_thr_reg <= pwdata[SLOPE_THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            CFG_REF_LEFT_EYE_X:  prdata = CFG_DATA_W'(ref_x_reg[0]);
            CFG_REF_LEFT_EYE_Y:  prdata = CFG_DATA_W'(ref_y_reg[0]);
            CFG_REF_RIGHT_EYE_X: prdata = CFG_DATA_W'(ref_x_reg[1]);
            CFG_REF_RIGHT_EYE_Y: prdata = CFG_DATA_W'(ref_y_reg[1]);
            CFG_REF_MOUTH_X:     prdata = CFG_DATA_W'(ref_x_reg[2]);
            CFG_REF_MOUTH_Y:     prdata = CFG_DATA_W'(ref_y_reg[2]);
            CFG_MOVE_THRESHOLD:  prdata = CFG_DATA_W'(move_thr_reg);
            CFG_SLOPE_THRESHOLD: prdata = CFG_DATA_W'(slope_thr_reg);
            default:             prdata = '0;
        endcase
    end

    assign ref_x = ref_x_reg;
    assign ref_y = ref_y_reg;
    assign thr.move_threshold  = move_thr_reg;
    assign thr.slope_threshold = slope_thr_reg;

endmodule

`default_nettype wire

FILE: src/flpc_measure.sv
// Stages 1 to 3: differences, squares and pair products, then side lengths,
// displacement sum and slope cross products. Depends on flpc_pkg.
`default_nettype none

module flpc_measure import flpc_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic [COORD_BITS-1:0]    cur_x [NUM_PTS],
    input  wire logic [COORD_BITS-1:0]    cur_y [NUM_PTS],
    input  wire logic [COORD_BITS-1:0]    ref_x [NUM_PTS],
    input  wire logic [COORD_BITS-1:0]    ref_y [NUM_PTS],
    output logic                          out_valid,
    output logic [2*COORD_BITS:0]         cur_side [NUM_PTS],
    output logic [2*COORD_BITS:0]         ref_side [NUM_PTS],
    output logic [2*COORD_BITS+2:0]       disp,
    output logic [3*COORD_BITS-1:0]       slope_term [NUM_PTS],
    output logic [3*COORD_BITS-1:0]       dx_prod,
    output move_flags_t                   flags
);

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SIDE_W = SQ_W + 1;
    localparam int DISP_W = SQ_W + 3;
    localparam int TRI_W  = 3 * COORD_BITS;

    function automatic logic [COORD_BITS-1:0] absd(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [SQ_W-1:0] sq(input logic [COORD_BITS-1:0] a);
        return SQ_W'(a) * SQ_W'(a);
    endfunction

    // stage 1
    logic                  v1_reg;
    logic [COORD_BITS-1:0] cdx_reg [NUM_PTS];
    logic [COORD_BITS-1:0] cdy_reg [NUM_PTS];
    logic [COORD_BITS-1:0] rdx_reg [NUM_PTS];
    logic [COORD_BITS-1:0] rdy_reg [NUM_PTS];
    logic [COORD_BITS-1:0] adx_reg [NUM_PTS];
    logic [COORD_BITS-1:0] ady_reg [NUM_PTS];
    logic                  dx_pos_reg;
    logic                  dy_pos_reg;

    // stage 2
    logic                  v2_reg;
    logic [SQ_W-1:0]       csx_reg [NUM_PTS];
    logic [SQ_W-1:0]       csy_reg [NUM_PTS];
    logic [SQ_W-1:0]       rsx_reg [NUM_PTS];
    logic [SQ_W-1:0]       rsy_reg [NUM_PTS];
    logic [SQ_W-1:0]       dsx_reg [NUM_PTS];
    logic [SQ_W-1:0]       dsy_reg [NUM_PTS];
    logic [SQ_W-1:0]       pair_reg [NUM_PTS];
    logic [COORD_BITS-1:0] ady2_reg [NUM_PTS];
    logic [COORD_BITS-1:0] adx0_reg;
    move_flags_t           flags2_reg;

    // stage 3
    logic                  v3_reg;
    logic [SIDE_W-1:0]     cur_side_reg [NUM_PTS];
    logic [SIDE_W-1:0]     ref_side_reg [NUM_PTS];
    logic [DISP_W-1:0]     disp_reg;
    logic [TRI_W-1:0]      term_reg [NUM_PTS];
    logic [TRI_W-1:0]      prod_reg;
    move_flags_t           flags3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // sides: left-right, left-mouth, right-mouth
            cdx_reg[0] <= absd(cur_x[0], cur_x[1]);
            cdy_reg[0] <= absd(cur_y[0], cur_y[1]);
            cdx_reg[1] <= absd(cur_x[0], cur_x[2]);
            cdy_reg[1] <= absd(cur_y[0], cur_y[2]);
            cdx_reg[2] <= absd(cur_x[1], cur_x[2]);
            cdy_reg[2] <= absd(cur_y[1], cur_y[2]);
            rdx_reg[0] <= absd(ref_x[0], ref_x[1]);
            rdy_reg[0] <= absd(ref_y[0], ref_y[1]);
            rdx_reg[1] <= absd(ref_x[0], ref_x[2]);
            rdy_reg[1] <= absd(ref_y[0], ref_y[2]);
            rdx_reg[2] <= absd(ref_x[1], ref_x[2]);
            rdy_reg[2] <= absd(ref_y[1], ref_y[2]);
            for (int i = 0; i < NUM_PTS; i++) begin
                adx_reg[i] <= absd(cur_x[i], ref_x[i]);
                ady_reg[i] <= absd(cur_y[i], ref_y[i]);
            end
            dx_pos_reg <= (cur_x[0] > ref_x[0]) && (cur_x[1] > ref_x[1])
                          && (cur_x[2] > ref_x[2]);
            dy_pos_reg <= (cur_y[0] > ref_y[0]) && (cur_y[1] > ref_y[1])
                          && (cur_y[2] > ref_y[2]);

            for (int i = 0; i < NUM_PTS; i++) begin
                csx_reg[i]  <= sq(cdx_reg[i]);
                csy_reg[i]  <= sq(cdy_reg[i]);
                rsx_reg[i]  <= sq(rdx_reg[i]);
                rsy_reg[i]  <= sq(rdy_reg[i]);
                dsx_reg[i]  <= sq(adx_reg[i]);
                dsy_reg[i]  <= sq(ady_reg[i]);
                ady2_reg[i] <= ady_reg[i];
            end
            // product of the two dx other than the indexed one
            pair_reg[0] <= SQ_W'(adx_reg[1]) * SQ_W'(adx_reg[2]);
            pair_reg[1] <= SQ_W'(adx_reg[0]) * SQ_W'(adx_reg[2]);
            pair_reg[2] <= SQ_W'(adx_reg[0]) * SQ_W'(adx_reg[1]);
            adx0_reg    <= adx_reg[0];
            flags2_reg.any_dx_zero <= (adx_reg[0] == '0) || (adx_reg[1] == '0)
                                      || (adx_reg[2] == '0);
            flags2_reg.all_dx_pos  <= dx_pos_reg;
            flags2_reg.all_dy_pos  <= dy_pos_reg;

            for (int i = 0; i < NUM_PTS; i++) begin
                cur_side_reg[i] <= SIDE_W'(csx_reg[i]) + SIDE_W'(csy_reg[i]);
                ref_side_reg[i] <= SIDE_W'(rsx_reg[i]) + SIDE_W'(rsy_reg[i]);
                term_reg[i]     <= TRI_W'(ady2_reg[i]) * TRI_W'(pair_reg[i]);
            end
            disp_reg <= DISP_W'(dsx_reg[0]) + DISP_W'(dsy_reg[0])
                      + DISP_W'(dsx_reg[1]) + DISP_W'(dsy_reg[1])
                      + DISP_W'(dsx_reg[2]) + DISP_W'(dsy_reg[2]);
            prod_reg   <= TRI_W'(pair_reg[0]) * TRI_W'(adx0_reg);
            flags3_reg <= flags2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign cur_side   = cur_side_reg;
    assign ref_side   = ref_side_reg;
    assign disp       = disp_reg;
    assign slope_term = term_reg;
    assign dx_prod    = prod_reg;
    assign flags      = flags3_reg;

endmodule

`default_nettype wire

FILE: src/flpc_decide.sv
// Stages 4 and 5: scale, movement and slope compares, then the posture code
// held in the output register. Depends on flpc_pkg.
`default_nettype none

module flpc_decide import flpc_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic [2*COORD_BITS:0]    cur_side [NUM_PTS],
    input  wire logic [2*COORD_BITS:0]    ref_side [NUM_PTS],
    input  wire logic [2*COORD_BITS+2:0]  disp,
    input  wire logic [3*COORD_BITS-1:0]  slope_term [NUM_PTS],
    input  wire logic [3*COORD_BITS-1:0]  dx_prod,
    input  wire move_flags_t              flags,
    input  wire thr_cfg_t                 thr,
    output logic                          out_valid,
    output posture_t                      posture
);

    localparam int SIDE_W = 2 * COORD_BITS + 1;
    localparam int SCL_W  = SIDE_W + 3;
    localparam int DISP_W = 2 * COORD_BITS + 3;
    localparam int DCMP_W = (DISP_W > MOVE_THR_W) ? DISP_W : MOVE_THR_W;
    localparam int TRI_W  = 3 * COORD_BITS;
    localparam int NUM_W  = TRI_W + 2;
    localparam int LIM_W  = TRI_W + SLOPE_THR_W;

    logic              v4_reg;
    logic              near_reg;
    logic              far_reg;
    logic              zero_ref_reg;
    logic              moved_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [LIM_W-1:0]  lim_reg;
    move_flags_t       flags4_reg;

    logic              v5_reg;
    posture_t          posture_reg;

    logic [SCL_W-1:0]  cur5 [NUM_PTS];
    logic [SCL_W-1:0]  ref6 [NUM_PTS];
    logic [SCL_W-1:0]  ref4 [NUM_PTS];
    logic              near_all;
    logic              far_all;
    logic              zero_any;
    logic              steep;
    posture_t          posture_next;

    always_comb begin
        near_all = 1'b1;
        far_all  = 1'b1;
        zero_any = 1'b0;
        for (int i = 0; i < NUM_PTS; i++) begin
            cur5[i] = (SCL_W'(cur_side[i]) << 2) + SCL_W'(cur_side[i]);
            ref6[i] = (SCL_W'(ref_side[i]) << 2) + (SCL_W'(ref_side[i]) << 1);
            ref4[i] = SCL_W'(ref_side[i]) << 2;
            if (!(cur5[i] > ref6[i])) near_all = 1'b0;
            if (!(cur5[i] < ref4[i])) far_all = 1'b0;
            if (ref_side[i] == '0) zero_any = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            near_reg     <= near_all;
            far_reg      <= far_all;
            zero_ref_reg <= zero_any;
            moved_reg    <= DCMP_W'(disp) > DCMP_W'(thr.move_threshold);
            num_reg      <= NUM_W'(slope_term[0]) + NUM_W'(slope_term[1])
                          + NUM_W'(slope_term[2]);
            lim_reg      <= LIM_W'(thr.slope_threshold) * LIM_W'(dx_prod);
            flags4_reg   <= flags;
            posture_reg  <= posture_next;
        end
    end

    always_comb begin
        steep = LIM_W'(num_reg) > lim_reg;
        if (zero_ref_reg) begin
            posture_next = POSTURE_NORMAL;
        end else if (near_reg) begin
            posture_next = POSTURE_NEAR;
        end else if (far_reg) begin
            posture_next = POSTURE_FAR;
        end else begin
            posture_next = POSTURE_NORMAL;
        end
        if (moved_reg) begin
            if (flags4_reg.any_dx_zero) begin
                posture_next = POSTURE_NORMAL;
            end else if (steep) begin
                posture_next = flags4_reg.all_dy_pos ? POSTURE_DOWN : POSTURE_UP;
            end else begin
                posture_next = flags4_reg.all_dx_pos ? POSTURE_LEFT : POSTURE_RIGHT;
            end
        end
    end

    assign out_valid = v5_reg;
    assign posture   = posture_reg;

endmodule

`default_nettype wire

FILE: src/face_landmark_posture_classifier_core.sv
// Top level of the face landmark posture classifier: APB registers and the
// five-stage classification pipeline. Depends on flpc_pkg, flpc_cfg,
// flpc_measure and flpc_decide.
//
// Usage:
//   s_ channel: one transfer carries the left eye, right eye and mouth
//   coordinates of a frame. m_ channel: one transfer per input transfer
//   carries the posture code (normal, near, far, left, right, up, down).
//   The APB port holds the reference triangle and the movement and slope
//   thresholds; write it only while no transfer is in flight.
//   Throughput is one transfer per cycle while m_ready does not stall the
//   pipeline; the pipeline depth is set by the squarer, the cross-product
//   multipliers and the final compare stage.
//   When m_ready is low with a result waiting, the whole pipeline holds and
//   s_ready drops in the same cycle; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline and returns the
//   registers to their defaults: reference points 0, move threshold 24000,
//   slope threshold 3.
`default_nettype none

module face_landmark_posture_classifier_core import flpc_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [COORD_BITS-1:0]  s_left_eye_x,
    input  wire logic [COORD_BITS-1:0]  s_left_eye_y,
    input  wire logic [COORD_BITS-1:0]  s_right_eye_x,
    input  wire logic [COORD_BITS-1:0]  s_right_eye_y,
    input  wire logic [COORD_BITS-1:0]  s_mouth_x,
    input  wire logic [COORD_BITS-1:0]  s_mouth_y,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [2:0]                  m_posture,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic      [CFG_DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic [COORD_BITS-1:0]     cur_x [NUM_PTS];
    logic [COORD_BITS-1:0]     cur_y [NUM_PTS];
    logic [COORD_BITS-1:0]     ref_x [NUM_PTS];
    logic [COORD_BITS-1:0]     ref_y [NUM_PTS];
    thr_cfg_t                  thr;
    logic                      en;
    logic                      mid_valid;
    logic [2*COORD_BITS:0]     cur_side [NUM_PTS];
    logic [2*COORD_BITS:0]     ref_side [NUM_PTS];
    logic [2*COORD_BITS+2:0]   disp;
    logic [3*COORD_BITS-1:0]   slope_term [NUM_PTS];
    logic [3*COORD_BITS-1:0]   dx_prod;
    move_flags_t               flags;
    posture_t                  posture;

    assign cur_x[0] = s_left_eye_x;
    assign cur_y[0] = s_left_eye_y;
    assign cur_x[1] = s_right_eye_x;
    assign cur_y[1] = s_right_eye_y;
    assign cur_x[2] = s_mouth_x;
    assign cur_y[2] = s_mouth_y;

    // pipeline advances unless the output register holds an untaken result
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    flpc_cfg #(
        .COORD_BITS(COORD_BITS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ref_x   (ref_x),
        .ref_y   (ref_y),
        .thr     (thr)
    );

    flpc_measure #(
        .COORD_BITS(COORD_BITS)
    ) u_measure (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .cur_x      (cur_x),
        .cur_y      (cur_y),
        .ref_x      (ref_x),
        .ref_y      (ref_y),
        .out_valid  (mid_valid),
        .cur_side   (cur_side),
        .ref_side   (ref_side),
        .disp       (disp),
        .slope_term (slope_term),
        .dx_prod    (dx_prod),
        .flags      (flags)
    );

    flpc_decide #(
        .COORD_BITS(COORD_BITS)
    ) u_decide (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (mid_valid),
        .cur_side   (cur_side),
        .ref_side   (ref_side),
        .disp       (disp),
        .slope_term (slope_term),
        .dx_prod    (dx_prod),
        .flags      (flags),
        .thr        (thr),
        .out_valid  (m_valid),
        .posture    (posture)
    );

    assign m_posture = posture;

endmodule

`default_nettype wire

FILE: test/tb_face_landmark_posture_classifier_core.sv
// Testbench for face_landmark_posture_classifier_core: sends landmark transfers
// under random idling and checks each posture code against an internal predictor.
// Depends on flpc_pkg and the core; standalone, no files or arguments.
`timescale 1ns / 100ps

module tb_face_landmark_posture_classifier_core;
    import flpc_pkg::*;

    localparam int COORD_BITS     = 12;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int MOVE_MAX       = (1 << MOVE_THR_W) - 1;
    localparam int SLOPE_MAX      = (1 << SLOPE_THR_W) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;

    typedef logic [COORD_BITS-1:0] coord_t;

    // index 0 left eye, 1 right eye, 2 mouth
    typedef struct packed {
        coord_t [2:0] x;
        coord_t [2:0] y;
    } landmarks_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    coord_t                s_left_eye_x = '0;
    coord_t                s_left_eye_y = '0;
    coord_t                s_right_eye_x = '0;
    coord_t                s_right_eye_y = '0;
    coord_t                s_mouth_x = '0;
    coord_t                s_mouth_y = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [2:0]            m_posture;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // register shadow
    coord_t                 base_x[3] = '{default: '0};
    coord_t                 base_y[3] = '{default: '0};
    logic [MOVE_THR_W-1:0]  move_thr  = MOVE_THR_RESET;
    logic [SLOPE_THR_W-1:0] slope_thr = SLOPE_THR_RESET;

    posture_t postures_due[$];
    posture_t due_posture;
    int       error_count = 0;
    int       stall_cycles = 0;
    bit       burst_input = 0;
    bit       ready_free = 0;
    int       ready_hold = 0;
    int       ready_run = 0;
    bit       ready_level = 0;

    face_landmark_posture_classifier_core #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_eye_x  (s_left_eye_x),
        .s_left_eye_y  (s_left_eye_y),
        .s_right_eye_x (s_right_eye_x),
        .s_right_eye_y (s_right_eye_y),
        .s_mouth_x     (s_mouth_x),
        .s_mouth_y     (s_mouth_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_posture     (m_posture),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic logic [63:0] abs_diff(input coord_t a, input coord_t b);
        return (a >= b) ? 64'(a) - 64'(b) : 64'(b) - 64'(a);
    endfunction

    function automatic logic [63:0] side_sq(input coord_t ax, input coord_t ay,
                                            input coord_t bx, input coord_t by);
        logic [63:0] dx, dy;
        dx = abs_diff(ax, bx);
        dy = abs_diff(ay, by);
        return dx * dx + dy * dy;
    endfunction

    function automatic posture_t predict_posture(input landmarks_t lm);
        logic [63:0] cur_sq, base_sq, disp, num, lim;
        logic [63:0] adx[3], ady[3];
        bit          near, far, zero_side, any_dx_zero, all_dx_pos, all_dy_pos;
        int          a, b;
        posture_t    result;
        near = 1;
        far = 1;
        zero_side = 0;
        any_dx_zero = 0;
        all_dx_pos = 1;
        all_dy_pos = 1;
        disp = 0;
        for (int i = 0; i < 3; i++) begin
            // sides: left-right, left-mouth, right-mouth
            a = (i == 2) ? 1 : 0;
            b = (i == 0) ? 1 : 2;
            cur_sq = side_sq(lm.x[a], lm.y[a], lm.x[b], lm.y[b]);
            base_sq = side_sq(base_x[a], base_y[a], base_x[b], base_y[b]);
            if (base_sq == 0) zero_side = 1;
            if (!(5 * cur_sq > 6 * base_sq)) near = 0;
            if (!(5 * cur_sq < 4 * base_sq)) far = 0;
            adx[i] = abs_diff(lm.x[i], base_x[i]);
            ady[i] = abs_diff(lm.y[i], base_y[i]);
            disp += adx[i] * adx[i] + ady[i] * ady[i];
            if (adx[i] == 0) any_dx_zero = 1;
            if (!(lm.x[i] > base_x[i])) all_dx_pos = 0;
            if (!(lm.y[i] > base_y[i])) all_dy_pos = 0;
        end
        if (zero_side) result = POSTURE_NORMAL;
        else if (near) result = POSTURE_NEAR;
        else if (far) result = POSTURE_FAR;
        else result = POSTURE_NORMAL;
        if (disp > 64'(move_thr)) begin
            if (any_dx_zero) begin
                result = POSTURE_NORMAL;
            end else begin
                // slope sum compared without division
                num = ady[0] * adx[1] * adx[2] + ady[1] * adx[0] * adx[2]
                    + ady[2] * adx[0] * adx[1];
                lim = 64'(slope_thr) * adx[0] * adx[1] * adx[2];
                if (num > lim) result = all_dy_pos ? POSTURE_DOWN : POSTURE_UP;
                else result = all_dx_pos ? POSTURE_LEFT : POSTURE_RIGHT;
            end
        end
        return result;
    endfunction

    function automatic coord_t clamp_coord(input int v);
        return coord_t'((v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic landmarks_t landmarks_of(input int lx, input int ly, input int rx,
                                                input int ry, input int mx, input int my);
        landmarks_t lm;
        lm.x[0] = clamp_coord(lx);
        lm.y[0] = clamp_coord(ly);
        lm.x[1] = clamp_coord(rx);
        lm.y[1] = clamp_coord(ry);
        lm.x[2] = clamp_coord(mx);
        lm.y[2] = clamp_coord(my);
        return lm;
    endfunction

    // mostly scaled or shifted copies of the reference triangle, some noise
    function automatic landmarks_t shaped_landmarks();
        landmarks_t lm;
        int         mode, pct, tx, ty, mag, cx, cy, jx, jy, k;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            for (int i = 0; i < 3; i++) begin
                lm.x[i] = coord_t'($urandom());
                lm.y[i] = coord_t'($urandom());
            end
            return lm;
        end
        cx = (int'(base_x[0]) + int'(base_x[1]) + int'(base_x[2])) / 3;
        cy = (int'(base_y[0]) + int'(base_y[1]) + int'(base_y[2])) / 3;
        if (mode < 5) begin
            pct = $urandom_range(60, 140);
            tx = $urandom_range(0, 8);
            ty = $urandom_range(0, 8);
            tx -= 4;
            ty -= 4;
        end else begin
            pct = $urandom_range(97, 103);
            mag = $urandom_range(20, 600);
            if (mode < 7) begin
                tx = mag;
                ty = $urandom_range(0, mag / 2);
            end else begin
                ty = mag;
                tx = $urandom_range(1, mag / 4 + 1);
            end
            if ($urandom_range(0, 1)) tx = -tx;
            if ($urandom_range(0, 1)) ty = -ty;
        end
        for (int i = 0; i < 3; i++) begin
            jx = $urandom_range(0, 4);
            jy = $urandom_range(0, 4);
            lm.x[i] = clamp_coord(cx + (int'(base_x[i]) - cx) * pct / 100 + tx + jx - 2);
            lm.y[i] = clamp_coord(cy + (int'(base_y[i]) - cy) * pct / 100 + ty + jy - 2);
        end
        if ($urandom_range(0, 7) == 0) begin
            k = $urandom_range(0, 2);
            lm.x[k] = base_x[k];
        end
        return lm;
    endfunction

    function automatic void random_reference(output int pts[6]);
        int size, cx, cy, off;
        size = ($urandom_range(0, 4) == 0) ? $urandom_range(600, 1800)
                                           : $urandom_range(6, 400);
        cx = $urandom_range(size, COORD_MAX - size);
        cy = $urandom_range(size, COORD_MAX - size);
        off = $urandom_range(0, size / 2);
        pts[0] = cx - size;
        pts[1] = cy - size / 3;
        pts[2] = cx + size;
        pts[3] = cy - size / 3;
        pts[4] = cx + off - size / 4;
        pts[5] = cy + size;
        // collapsed side
        if ($urandom_range(0, 5) == 0) begin
            pts[4] = pts[0];
            pts[5] = pts[1];
        end
    endfunction

    function automatic int input_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_landmarks(input landmarks_t lm);
        int gap;
        gap = burst_input ? 0 : input_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_left_eye_x <= lm.x[0];
        s_left_eye_y <= lm.y[0];
        s_right_eye_x <= lm.x[1];
        s_right_eye_y <= lm.y[1];
        s_mouth_x <= lm.x[2];
        s_mouth_y <= lm.y[2];
        do @(posedge aclk); while (!s_ready);
        postures_due.insert(postures_due.size(), predict_posture(lm));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (postures_due.size() != 0);
    endtask

    // back-to-back APB writes of all registers; upper bits sometimes garbage
    task automatic load_config(input int lx, input int ly, input int rx, input int ry,
                               input int mx, input int my, input int move, input int slope);
        logic [31:0] value[8];
        logic [31:0] data;
        cfg_idx_t    idx;
        int          width;
        value = '{lx, ly, rx, ry, mx, my, move, slope};
        for (int i = 0; i < 8; i++) begin
            idx = cfg_idx_t'(i);
            case (idx)
                CFG_MOVE_THRESHOLD:  width = MOVE_THR_W;
                CFG_SLOPE_THRESHOLD: width = SLOPE_THR_W;
                default:             width = COORD_BITS;
            endcase
            data = value[i] & ((32'h1 << width) - 1);
            if ($urandom_range(0, 2) == 0) data = data | ($urandom() << width);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= CFG_ADDR_W'(i * 4);
            pwdata <= data;
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            case (idx)
                CFG_REF_LEFT_EYE_X:  base_x[0] = data[COORD_BITS-1:0];
                CFG_REF_LEFT_EYE_Y:  base_y[0] = data[COORD_BITS-1:0];
                CFG_REF_RIGHT_EYE_X: base_x[1] = data[COORD_BITS-1:0];
                CFG_REF_RIGHT_EYE_Y: base_y[1] = data[COORD_BITS-1:0];
                CFG_REF_MOUTH_X:     base_x[2] = data[COORD_BITS-1:0];
                CFG_REF_MOUTH_Y:     base_y[2] = data[COORD_BITS-1:0];
                CFG_MOVE_THRESHOLD:  move_thr = data[MOVE_THR_W-1:0];
                CFG_SLOPE_THRESHOLD: slope_thr = data[SLOPE_THR_W-1:0];
                default: ;
            endcase
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // reset registers: zero reference, so only the direction step can fire
    task automatic test_reset_defaults();
        send_landmarks(landmarks_of(0, 0, 0, 0, 0, 0));
        send_landmarks(landmarks_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                    COORD_MAX, COORD_MAX));
        send_landmarks(landmarks_of(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555));
        send_landmarks(landmarks_of(COORD_MAX, 0, 0, COORD_MAX, COORD_MAX, 0));
    endtask

    task automatic test_directed_postures();
        wait_drained();
        load_config(1000, 1000, 1200, 1000, 1100, 1200,
                    int'(MOVE_THR_RESET), int'(SLOPE_THR_RESET));
        send_landmarks(landmarks_of(1000, 1000, 1200, 1000, 1100, 1200)); // unchanged
        send_landmarks(landmarks_of(990, 990, 1210, 990, 1100, 1220));    // near
        send_landmarks(landmarks_of(1012, 1012, 1188, 1012, 1100, 1176)); // far
        send_landmarks(landmarks_of(1100, 1010, 1300, 1010, 1200, 1210)); // left
        send_landmarks(landmarks_of(900, 1010, 1100, 1010, 1000, 1210));  // right
        send_landmarks(landmarks_of(1010, 900, 1210, 900, 1110, 1100));   // up
        send_landmarks(landmarks_of(990, 1100, 1190, 1100, 1090, 1300));  // down
        send_landmarks(landmarks_of(1010, 1100, 1210, 1100, 1110, 1100)); // steep, mixed dy
        send_landmarks(landmarks_of(1000, 1200, 1250, 1200, 1150, 1400)); // zero dx
        send_landmarks(landmarks_of(1100, 1100, 1300, 1100, 1200, 1300)); // slope sum at limit
        send_landmarks(landmarks_of(1100, 1101, 1300, 1101, 1200, 1301)); // just above limit
        send_landmarks(landmarks_of(0, 0, 0, 0, 0, 0));
        send_landmarks(landmarks_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                    COORD_MAX, COORD_MAX));
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        wait_drained();
        ready_hold = 300;
        burst_input = 1;
        repeat (40) send_landmarks(shaped_landmarks());
        burst_input = 0;
        wait_drained();
    endtask

    task automatic test_config_sweep();
        int pts[6];
        int move, slope;
        for (int phase = 0; phase < 10; phase++) begin
            wait_drained();
            random_reference(pts);
            case ($urandom_range(0, 3))
                0: move = $urandom_range(0, 5000);
                1: move = $urandom_range(5000, 200000);
                2: move = int'(MOVE_THR_RESET);
                default: move = $urandom_range(0, MOVE_MAX);
            endcase
            slope = $urandom_range(0, SLOPE_MAX);
            case (phase)
                0: load_config(0, 0, COORD_MAX, 0, 2048, COORD_MAX, 0, 0);
                1: load_config(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                               COORD_MAX, MOVE_MAX, SLOPE_MAX);
                2: load_config(pts[0], pts[1], pts[2], pts[3], pts[4], pts[5], 0, SLOPE_MAX);
                3: load_config(pts[0], pts[1], pts[2], pts[3], pts[4], pts[5], MOVE_MAX, 0);
                default: load_config(pts[0], pts[1], pts[2], pts[3], pts[4], pts[5],
                                     move, slope);
            endcase
            repeat (60) send_landmarks(shaped_landmarks());
        end
    endtask

    task automatic test_random_streaming();
        int pts[6];
        wait_drained();
        random_reference(pts);
        load_config(pts[0], pts[1], pts[2], pts[3], pts[4], pts[5],
                    $urandom_range(0, 60000), $urandom_range(0, SLOPE_MAX));
        ready_free = 1;
        burst_input = 1;
        repeat (100) send_landmarks(shaped_landmarks());
        ready_free = 0;
        burst_input = 0;
        repeat (240) send_landmarks(shaped_landmarks());
    endtask

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_ready <= 1'b0;
        end else if (ready_free) begin
            m_ready <= 1'b1;
        end else begin
            if (ready_run == 0) begin
                ready_level = !ready_level;
                if (ready_level) ready_run = $urandom_range(1, 24);
                else if ($urandom_range(0, 9) == 0) ready_run = $urandom_range(15, 60);
                else ready_run = $urandom_range(1, 3);
            end
            ready_run = ready_run - 1;
            m_ready <= ready_level;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (postures_due.size() == 0) begin
                $error("posture transfer %0d with no expectation pending", m_posture);
                error_count++;
            end else begin
                due_posture = postures_due.pop_front();
                if (m_posture !== due_posture) begin
                    $error("posture mismatch: expected %0d, actual %0d",
                           due_posture, m_posture);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed_postures();
        test_backpressure();
        test_config_sweep();
        test_random_streaming();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (postures_due.size() != 0) begin
            $error("%0d posture results never arrived", postures_due.size());
            error_count++;
        end
        if (error_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
